// ----- rtl/mpq_pkg.sv -----
package mpq_pkg;

    localparam int CAPACITY = 128;
    localparam int DATA_W   = 32;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_PEEK   = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // what the cell chain does this cycle
    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_SHIFT  = 2'd2
    } op_t;

    // broadcast to every cell
    typedef struct packed {
        op_t                       op;
        logic signed [DATA_W-1:0] new_value;
        logic signed [DATA_W-1:0] new_prio;
    } cell_ctrl_t;

endpackage

// ----- rtl/max_priority_queue.sv -----
// Bounded max-priority queue built as a sorted chain of cells. Cell 0 always
// holds the highest-priority entry; ties keep arrival order, so the earliest
// of equal priorities is served first. A command beat is taken whenever start
// is high (busy stays low: every command completes without stalling), and its
// result appears in the next cycle for exactly one cycle with done high. The
// receiver cannot stall, so results must be captured on the done cycle.
// Throughput is 1 command per cycle; the limiting path is one
// 32-bit signed compare per cell against the broadcast insert priority.
// Insert on a full queue returns status full; remove or peek on an empty queue
// returns status empty; an undefined command code returns done and changes
// nothing. The value and priority outputs are zero unless an entry is returned.
module max_priority_queue #(
    parameter int CAPACITY = mpq_pkg::CAPACITY
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        command,
    input  logic signed [mpq_pkg::DATA_W-1:0] value,
    input  logic signed [mpq_pkg::DATA_W-1:0] priority_req,
    output logic                              done,
    output logic [1:0]                        status,
    output logic signed [mpq_pkg::DATA_W-1:0] out_value,
    output logic signed [mpq_pkg::DATA_W-1:0] out_priority
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    // occupancy count; cells at index >= count hold stale data
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    logic                       done_reg;
    mpq_pkg::status_t           status_reg;
    mpq_pkg::status_t           status_next;
    logic signed [mpq_pkg::DATA_W-1:0] out_value_reg;
    logic signed [mpq_pkg::DATA_W-1:0] out_value_next;
    logic signed [mpq_pkg::DATA_W-1:0] out_prio_reg;
    logic signed [mpq_pkg::DATA_W-1:0] out_prio_next;

    mpq_pkg::cell_ctrl_t ctrl;

    logic                              is_full;
    logic                              is_empty;

    // per-cell taps
    logic signed [mpq_pkg::DATA_W-1:0] cell_value [CAPACITY];
    logic signed [mpq_pkg::DATA_W-1:0] cell_prio  [CAPACITY];
    logic                              cell_flag  [CAPACITY];
    logic                              cell_occ   [CAPACITY];
    logic                              left_flag  [CAPACITY];
    logic signed [mpq_pkg::DATA_W-1:0] left_value [CAPACITY];
    logic signed [mpq_pkg::DATA_W-1:0] left_prio  [CAPACITY];
    logic signed [mpq_pkg::DATA_W-1:0] right_value[CAPACITY];
    logic signed [mpq_pkg::DATA_W-1:0] right_prio [CAPACITY];

    assign is_full  = (count_reg == CNT_W'(CAPACITY));
    assign is_empty = (count_reg == '0);

    // commands never stall, never busy
    assign busy = 1'b0;

    // command decode: chain op, count update, result beat
    always_comb
    begin
        ctrl.op        = mpq_pkg::OP_HOLD;
        ctrl.new_value = value;
        ctrl.new_prio  = priority_req;
        count_next     = count_reg;
        status_next    = mpq_pkg::ST_DONE;
        out_value_next = '0;
        out_prio_next  = '0;
        if (start)
        begin
            unique case (mpq_pkg::cmd_t'(command))
                mpq_pkg::CMD_INSERT:
                begin
                    if (is_full)
                    begin
                        status_next = mpq_pkg::ST_FULL;
                    end
                    else
                    begin
                        ctrl.op    = mpq_pkg::OP_INSERT;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                mpq_pkg::CMD_REMOVE:
                begin
                    if (is_empty)
                    begin
                        status_next = mpq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        ctrl.op        = mpq_pkg::OP_SHIFT;
                        count_next     = count_reg - CNT_W'(1);
                        out_value_next = cell_value[0];
                        out_prio_next  = cell_prio[0];
                    end
                end
                mpq_pkg::CMD_PEEK:
                begin
                    if (is_empty)
                    begin
                        status_next = mpq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        out_value_next = cell_value[0];
                        out_prio_next  = cell_prio[0];
                    end
                end
                default:
                begin
                    status_next = mpq_pkg::ST_DONE;
                end
            endcase
        end
    end

    // cell chain: neighbors wired, ends tied off
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        assign cell_occ[g] = (CNT_W'(g) < count_reg);

        if (g == 0)
        begin : g_head
            assign left_flag[g]  = 1'b0;
            assign left_value[g] = value;
            assign left_prio[g]  = priority_req;
        end
        else
        begin : g_mid
            assign left_flag[g]  = cell_flag[g-1];
            assign left_value[g] = cell_value[g-1];
            assign left_prio[g]  = cell_prio[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_tail
            assign right_value[g] = cell_value[g];
            assign right_prio[g]  = cell_prio[g];
        end
        else
        begin : g_body
            assign right_value[g] = cell_value[g+1];
            assign right_prio[g]  = cell_prio[g+1];
        end

        mpq_cell u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .occ         (cell_occ[g]),
            .left_flag   (left_flag[g]),
            .left_value  (left_value[g]),
            .left_prio   (left_prio[g]),
            .right_value (right_value[g]),
            .right_prio  (right_prio[g]),
            .value       (cell_value[g]),
            .prio        (cell_prio[g]),
            .flag        (cell_flag[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= start;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        status_reg    <= status_next;
        out_value_reg <= out_value_next;
        out_prio_reg  <= out_prio_next;
    end

    assign done         = done_reg;
    assign status       = 2'(status_reg);
    assign out_value    = out_value_reg;
    assign out_priority = out_prio_reg;

`ifndef SYNTH
    a_beat_follows: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> done)
        else $error("command beat gave no result");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !start |=> !done)
        else $error("result without command");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("count beyond capacity");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status_reg == mpq_pkg::ST_FULL) |-> is_full)
        else $error("full reported on non-full queue");

    a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status_reg == mpq_pkg::ST_EMPTY) |-> is_empty)
        else $error("empty reported on non-empty queue");
`endif

endmodule

// ----- rtl/mpq_cell.sv -----
module mpq_cell (
    input  logic                              clk,
    input  mpq_pkg::cell_ctrl_t               ctrl,
    input  logic                              occ,
    input  logic                              left_flag,
    input  logic signed [mpq_pkg::DATA_W-1:0] left_value,
    input  logic signed [mpq_pkg::DATA_W-1:0] left_prio,
    input  logic signed [mpq_pkg::DATA_W-1:0] right_value,
    input  logic signed [mpq_pkg::DATA_W-1:0] right_prio,
    output logic signed [mpq_pkg::DATA_W-1:0] value,
    output logic signed [mpq_pkg::DATA_W-1:0] prio,
    output logic                              flag
);

    logic signed [mpq_pkg::DATA_W-1:0] value_reg;
    logic signed [mpq_pkg::DATA_W-1:0] value_next;
    logic signed [mpq_pkg::DATA_W-1:0] prio_reg;
    logic signed [mpq_pkg::DATA_W-1:0] prio_next;

    // chain is sorted: flag is low up to the insertion point, high from it on
    assign flag  = !occ || (ctrl.new_prio > prio_reg);
    assign value = value_reg;
    assign prio  = prio_reg;

    always_comb
    begin
        value_next = value_reg;
        prio_next  = prio_reg;
        unique case (ctrl.op)
            mpq_pkg::OP_INSERT:
            begin
                if (flag && !left_flag)
                begin
                    value_next = ctrl.new_value;
                    prio_next  = ctrl.new_prio;
                end
                else if (flag)
                begin
                    value_next = left_value;
                    prio_next  = left_prio;
                end
            end
            mpq_pkg::OP_SHIFT:
            begin
                value_next = right_value;
                prio_next  = right_prio;
            end
            default:
            begin
                value_next = value_reg;
                prio_next  = prio_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        prio_reg  <= prio_next;
    end

endmodule
